// File: rtl/aspg_pkg.sv
// Shared types, constants and helper functions for the send-probability gate.
package aspg_pkg;

    localparam int unsigned PROB_W    = 16;
    localparam int unsigned CHILD_W   = 4;
    localparam int unsigned MODE_W    = 2;

    localparam logic [PROB_W-1:0]  PROB_MAX  = 16'hFFFF;
    localparam logic [CHILD_W-1:0] CHILD_MAX = 4'd9;

    typedef enum logic [MODE_W-1:0] {
        MODE_OWN_SEND   = 2'd0,
        MODE_ROUTE_SEND = 2'd1,
        MODE_OWN_ACK    = 2'd2,
        MODE_ROUTE_ACK  = 2'd3
    } mode_t;

    typedef struct packed {
        logic              granted;
        logic              phase_change;
        logic [PROB_W-1:0] own_probability;
        logic [PROB_W-1:0] route_probability;
    } result_t;

    // Additive increase step, selected by the number of children.
    function automatic logic [PROB_W-1:0] step_lookup(input logic [CHILD_W-1:0] children);
        logic [PROB_W-1:0] step;
        case (children)
            4'd0:    step = 16'd6553;
            4'd1:    step = 16'd3276;
            4'd2:    step = 16'd2184;
            4'd3:    step = 16'd1638;
            4'd4:    step = 16'd1320;
            4'd5:    step = 16'd1092;
            4'd6:    step = 16'd936;
            4'd7:    step = 16'd819;
            4'd8:    step = 16'd655;
            default: step = 16'd595;
        endcase
        return step;
    endfunction

    // Add the step, saturating at the top of the range.
    function automatic logic [PROB_W-1:0] raise_prob(input logic [PROB_W-1:0] prob,
                                                     input logic [PROB_W-1:0] step);
        logic [PROB_W-1:0] result;
        if (prob < (PROB_MAX - step))
        begin
            result = prob + step;
        end
        else
        begin
            result = PROB_MAX;
        end
        return result;
    endfunction

endpackage

// File: rtl/adaptive_send_probability_gate_core.sv
// Top level of the adaptive send-probability gate: state, update logic and result buffering.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------------
//  in       | sink      | in_valid / in_stall | mode, rand_value, link_accepts
//  out      | source    | out_valid/out_stall | granted, phase_change, own_probability,
//           |           |                     | route_probability
//  cfg      | sink      | cfg_valid/cfg_ready | cfg_data (child_count, clamped to 9)
//
// One request is taken per cycle while in_stall is low; its result is registered in
// the output register, or in the skid register if the output is held by a stall.
// Reset puts both probabilities at full scale, clears both pending flags and the
// child count, and empties the output and skid registers.
// A stalled output keeps taking requests: the first waiting result sits in the
// output register, the next in the skid register, and only then is in_stall raised.
module adaptive_send_probability_gate_core
    import aspg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [PROB_W-1:0]   rand_value,
    input  logic                link_accepts,

    output logic                out_valid,
    input  logic                out_stall,
    output logic                granted,
    output logic                phase_change,
    output logic [PROB_W-1:0]   own_probability,
    output logic [PROB_W-1:0]   route_probability,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CHILD_W-1:0]  cfg_data
);

    // Gate state
    logic [PROB_W-1:0]  own_prob_reg,      own_prob_next;
    logic [PROB_W-1:0]  route_prob_reg,    route_prob_next;
    logic               own_pending_reg,   own_pending_next;
    logic               route_pending_reg, route_pending_next;
    logic [CHILD_W-1:0] child_count_reg,   child_count_next;

    // Output register and skid stage
    result_t            out_data_reg,  out_data_next;
    logic               out_valid_reg, out_valid_next;
    result_t            skid_data_reg, skid_data_next;
    logic               skid_valid_reg, skid_valid_next;

    result_t            result;
    logic               in_fire;
    logic               out_fire;
    logic               own_hit;
    logic               route_hit;
    logic [PROB_W-1:0]  own_base;
    logic [PROB_W-1:0]  route_base;

    assign in_stall  = skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;

    // Clamp the child count as it is written.
    always_comb
    begin
        child_count_next = child_count_reg;
        if (cfg_valid)
        begin
            child_count_next = (cfg_data > CHILD_MAX) ? CHILD_MAX : cfg_data;
        end
    end

    assign own_hit   = (own_prob_reg >= rand_value);
    assign route_hit = (route_prob_reg >= rand_value);

    // Event update: lottery, multiplicative cut on a still-pending send, then
    // additive increase. A refused send leaves the state alone; an acknowledge clears the pending flag.
    always_comb
    begin
        own_prob_next      = own_prob_reg;
        route_prob_next    = route_prob_reg;
        own_pending_next   = own_pending_reg;
        route_pending_next = route_pending_reg;
        own_base           = own_prob_reg;
        route_base         = route_prob_reg;
        result.granted      = 1'b0;
        result.phase_change = 1'b0;

        unique case (mode_t'(mode))
            MODE_OWN_SEND:
            begin
                if (own_hit && !link_accepts)
                begin
                    // refused by the link: signal a phase change, hold state
                    result.phase_change = 1'b1;
                end
                else
                begin
                    if (own_hit)
                    begin
                        result.granted = 1'b1;
                        if (own_pending_reg)
                        begin
                            own_base            = own_prob_reg >> 1;
                            result.phase_change = 1'b1;
                        end
                        own_pending_next = 1'b1;
                    end
                    own_prob_next = raise_prob(own_base, step_lookup(child_count_reg));
                end
            end
            MODE_ROUTE_SEND:
            begin
                if (!(route_hit && !link_accepts))
                begin
                    if (route_hit)
                    begin
                        result.granted = 1'b1;
                        if (route_pending_reg)
                        begin
                            route_base = route_prob_reg - (route_prob_reg >> 2);
                        end
                        route_pending_next = 1'b1;
                    end
                    route_prob_next = raise_prob(route_base, step_lookup('0));
                end
            end
            MODE_OWN_ACK:
            begin
                own_pending_next = 1'b0;
            end
            MODE_ROUTE_ACK:
            begin
                route_pending_next = 1'b0;
            end
            default:
            begin
                own_pending_next = own_pending_reg;
            end
        endcase

        result.own_probability   = own_prob_next;
        result.route_probability = route_prob_next;
    end

    // Steer the result into the output register, or the skid stage if the
    // output is still held by a stall.
    always_comb
    begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_valid_next = skid_valid_reg;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                // advance the skid entry into the output register
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_next  = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_prob_reg      <= PROB_MAX;
            route_prob_reg    <= PROB_MAX;
            own_pending_reg   <= 1'b0;
            route_pending_reg <= 1'b0;
            child_count_reg   <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            child_count_reg <= child_count_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
            if (in_fire)
            begin
                own_prob_reg      <= own_prob_next;
                route_prob_reg    <= route_prob_next;
                own_pending_reg   <= own_pending_next;
                route_pending_reg <= route_pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid         = out_valid_reg;
    assign granted           = out_data_reg.granted;
    assign phase_change      = out_data_reg.phase_change;
    assign own_probability   = out_data_reg.own_probability;
    assign route_probability = out_data_reg.route_probability;

endmodule

// File: rtl/aspg_checker.sv
// Port-level checker for the send-probability gate, bound to the top level.
module aspg_checker
    import aspg_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic                granted,
    input logic                phase_change,
    input logic [PROB_W-1:0]   own_probability,
    input logic [PROB_W-1:0]   route_probability
);

    // A held result keeps its valid and payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(granted) && $stable(phase_change)
            && $stable(own_probability) && $stable(route_probability))
        else $error("held result changed");

    // Requests are only refused once the output register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // No result appears without a request taken the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !(in_valid && !in_stall) |=> !out_valid)
        else $error("result without request");

    // Additive increase keeps both probabilities above their smallest step.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (route_probability >= 16'd6553) && (own_probability >= 16'd595))
        else $error("probability below floor");

endmodule

bind adaptive_send_probability_gate_core aspg_checker u_aspg_checker (.*);
